// ===== rtl/mmpw_pkg.sv =====
`default_nettype none

package mmpw_pkg;

  // default sizing of the pattern store
  localparam int NumPatterns  = 9;
  localparam int PatternBytes = 22;

  // field widths
  localparam int CmdW    = 2;
  localparam int ValueW  = 8;
  localparam int IdxW    = 4;
  localparam int PosW    = 5;
  localparam int SecsW   = 9;
  localparam int StatusW = 2;
  localparam int TickW   = 16;

  // timeout scaling
  localparam logic [TickW-1:0] TicksPerSec  = 16'd100;
  localparam logic [TickW-1:0] DefaultTicks = 16'd4000;

  // queue between front and back
  localparam int QueueDepth = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_RX    = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_IDLE    = 2'd0,
    ST_WAITING = 2'd1,
    ST_MATCHED = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  // decoded item handed from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic [ValueW-1:0] value;
    logic [IdxW-1:0]   row;
    logic [PosW-1:0]   col;
    logic              wr_ok;   // load lands inside the store
    logic [TickW-1:0]  reload;  // timeout for a start item
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/mmpw_in_if.sv =====
`default_nettype none

interface mmpw_in_if;
  logic                             valid;
  logic                             ready;
  logic [mmpw_pkg::CmdW-1:0]        command;
  logic [mmpw_pkg::ValueW-1:0]      value;
  logic [mmpw_pkg::IdxW-1:0]        pattern_index;
  logic [mmpw_pkg::PosW-1:0]        char_pos;
  logic [mmpw_pkg::SecsW-1:0]       wait_seconds;

  modport source (output valid, command, value, pattern_index, char_pos, wait_seconds,
                  input ready);
  modport sink   (input valid, command, value, pattern_index, char_pos, wait_seconds,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/mmpw_out_if.sv =====
`default_nettype none

interface mmpw_out_if;
  logic                          valid;
  logic                          ready;
  logic [mmpw_pkg::StatusW-1:0]  status;
  logic [mmpw_pkg::IdxW-1:0]     match_index;

  modport source (output valid, status, match_index, input ready);
  modport sink   (input valid, status, match_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/mmpw_ram.sv =====
`default_nettype none

module mmpw_ram #(
  parameter int Width = 8,
  parameter int Depth = 22
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mmpw_front.sv =====
`default_nettype none

module mmpw_front #(
  parameter int NUM_PATTERNS  = mmpw_pkg::NumPatterns,
  parameter int PATTERN_BYTES = mmpw_pkg::PatternBytes
) (
  mmpw_in_if.sink            in_ch,
  input  wire logic          q_full,
  output logic               push,
  output mmpw_pkg::op_t      push_op
);

  logic [mmpw_pkg::TickW-1:0] ticks;

  // accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // timeout length: seconds * 100, zero selects the default
  assign ticks = mmpw_pkg::TickW'(in_ch.wait_seconds) * mmpw_pkg::TicksPerSec;

  // classify the item
  always_comb begin
    push_op.cmd    = mmpw_pkg::cmd_t'(in_ch.command);
    push_op.value  = in_ch.value;
    push_op.row    = in_ch.pattern_index;
    push_op.col    = in_ch.char_pos;
    push_op.wr_ok  = (int'(in_ch.pattern_index) < NUM_PATTERNS) &&
                     (int'(in_ch.char_pos) < PATTERN_BYTES - 1);
    push_op.reload = (in_ch.wait_seconds == '0) ? mmpw_pkg::DefaultTicks : ticks;
  end

endmodule

`default_nettype wire

// ===== rtl/mmpw_queue.sv =====
`default_nettype none

module mmpw_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mmpw_pkg::op_t  push_op,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output mmpw_pkg::op_t       pop_op
);

  localparam int PtrW = $clog2(mmpw_pkg::QueueDepth);
  localparam int CntW = $clog2(mmpw_pkg::QueueDepth + 1);

  mmpw_pkg::op_t    entry_r [mmpw_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]  cnt_r;

  assign full      = (cnt_r == CntW'(mmpw_pkg::QueueDepth));
  assign not_empty = (cnt_r != '0);
  assign pop_op    = entry_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CntW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mmpw_back.sv =====
`default_nettype none

module mmpw_back #(
  parameter int NUM_PATTERNS  = mmpw_pkg::NumPatterns,
  parameter int PATTERN_BYTES = mmpw_pkg::PatternBytes
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           op_valid,
  input  wire mmpw_pkg::op_t  op,
  output logic                op_pop,
  mmpw_out_if.source          out_ch
);

  localparam int AW = $clog2(PATTERN_BYTES);
  localparam logic [AW-1:0] LastPos = AW'(PATTERN_BYTES - 1);

  logic                          go, rx_any, rx_act, tick_act, is_start, expire;
  logic                          any_done, finish, clear;
  logic [mmpw_pkg::IdxW-1:0]     hit_idx;
  logic [AW-1:0]                 waddr;
  logic [NUM_PATTERNS-1:0]       hit, done, we;
  logic [NUM_PATTERNS-1:0]       rd_vld_r, byp_r;
  logic [AW-1:0]                 pos_r   [NUM_PATTERNS];
  logic [AW-1:0]                 pos_nxt [NUM_PATTERNS];
  logic [AW-1:0]                 raddr   [NUM_PATTERNS];
  logic [mmpw_pkg::ValueW-1:0]   cur_r     [NUM_PATTERNS];
  logic [mmpw_pkg::ValueW-1:0]   cur_nxt   [NUM_PATTERNS];
  logic [mmpw_pkg::ValueW-1:0]   byte0_r   [NUM_PATTERNS];
  logic [mmpw_pkg::ValueW-1:0]   ram_q     [NUM_PATTERNS];
  logic [mmpw_pkg::ValueW-1:0]   nx_byte   [NUM_PATTERNS];
  logic [mmpw_pkg::ValueW-1:0]   byp_dat_r [NUM_PATTERNS];
  logic [PATTERN_BYTES-1:0]      vld_r     [NUM_PATTERNS];

  logic                          waiting_r;
  logic [mmpw_pkg::TickW-1:0]    idle_r, reload_r, idle_dec;

  logic                          out_valid_r;
  mmpw_pkg::status_t             out_status_r, status_nxt;
  logic [mmpw_pkg::IdxW-1:0]     out_midx_r, midx_nxt;

  // execute one item per cycle while the output slot is free or draining
  assign go     = op_valid && (!out_valid_r || out_ch.ready);
  assign op_pop = go;

  assign rx_any   = go && (op.cmd == mmpw_pkg::CMD_RX) && waiting_r;
  assign rx_act   = rx_any && (op.value != '0);
  assign tick_act = go && (op.cmd == mmpw_pkg::CMD_TICK) && waiting_r;
  assign is_start = go && (op.cmd == mmpw_pkg::CMD_START);
  assign idle_dec = (idle_r != '0) ? idle_r - mmpw_pkg::TickW'(1) : '0;
  assign expire   = tick_act && (idle_dec == '0);
  assign finish   = (rx_act && any_done) || expire;
  assign clear    = finish || is_start;
  assign waddr    = AW'(op.col);

  // per-pattern matchers; cur holds store[pos], the RAM delivers store[pos+1]
  for (genvar i = 0; i < NUM_PATTERNS; i++) begin : g_pat

    assign we[i] = go && (op.cmd == mmpw_pkg::CMD_LOAD) && op.wr_ok &&
                   (op.row == mmpw_pkg::IdxW'(i));

    // next expected byte, with same-cycle write forwarding and empty entries
    assign nx_byte[i] = byp_r[i]    ? byp_dat_r[i] :
                        rd_vld_r[i] ? ram_q[i]     : '0;

    assign hit[i]  = (pos_r[i] < LastPos) && (cur_r[i] == op.value);
    assign done[i] = hit[i] && (nx_byte[i] == '0);

    // position and current byte update
    always_comb begin
      pos_nxt[i] = pos_r[i];
      cur_nxt[i] = cur_r[i];
      if (clear || (rx_act && !hit[i])) begin
        pos_nxt[i] = '0;
        cur_nxt[i] = byte0_r[i];
      end else if (rx_act) begin
        pos_nxt[i] = pos_r[i] + AW'(1);
        cur_nxt[i] = nx_byte[i];
      end else if (we[i] && (waddr == pos_r[i])) begin
        cur_nxt[i] = op.value;
      end
    end

    assign raddr[i] = pos_nxt[i] + AW'(1);

    mmpw_ram #(
      .Width (mmpw_pkg::ValueW),
      .Depth (PATTERN_BYTES)
    ) u_row (
      .clk   (clk),
      .we    (we[i]),
      .waddr (waddr),
      .wdata (op.value),
      .raddr (raddr[i]),
      .rdata (ram_q[i])
    );

    // control and store-shadow registers
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pos_r[i]    <= '0;
        cur_r[i]    <= '0;
        byte0_r[i]  <= '0;
        vld_r[i]    <= '0;
        rd_vld_r[i] <= 1'b0;
        byp_r[i]    <= 1'b0;
      end else begin
        pos_r[i]    <= pos_nxt[i];
        cur_r[i]    <= cur_nxt[i];
        rd_vld_r[i] <= vld_r[i][raddr[i]];
        byp_r[i]    <= we[i] && (waddr == raddr[i]);
        if (we[i]) begin
          vld_r[i][waddr] <= 1'b1;
          if (waddr == '0) begin
            byte0_r[i] <= op.value;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      byp_dat_r[i] <= op.value;
    end
  end

  // lowest-index completed pattern wins
  always_comb begin
    any_done = 1'b0;
    hit_idx  = '0;
    for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
      if (done[i]) begin
        any_done = 1'b1;
        hit_idx  = mmpw_pkg::IdxW'(i);
      end
    end
  end

  // result of the item
  always_comb begin
    status_nxt = waiting_r ? mmpw_pkg::ST_WAITING : mmpw_pkg::ST_IDLE;
    midx_nxt   = '0;
    unique case (op.cmd)
      mmpw_pkg::CMD_RX: begin
        if (rx_act && any_done) begin
          status_nxt = mmpw_pkg::ST_MATCHED;
          midx_nxt   = hit_idx;
        end
      end
      mmpw_pkg::CMD_START: begin
        status_nxt = mmpw_pkg::ST_WAITING;
      end
      mmpw_pkg::CMD_TICK: begin
        if (expire) begin
          status_nxt = mmpw_pkg::ST_TIMEOUT;
        end
      end
      default: begin
      end
    endcase
  end

  // wait state and inactivity counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      idle_r    <= '0;
      reload_r  <= '0;
    end else begin
      if (is_start) begin
        waiting_r <= 1'b1;
        idle_r    <= op.reload;
        reload_r  <= op.reload;
      end else begin
        if (finish) begin
          waiting_r <= 1'b0;
        end
        if (rx_any) begin
          idle_r <= reload_r;
        end else if (tick_act) begin
          idle_r <= idle_dec;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_status_r <= status_nxt;
      out_midx_r   <= midx_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.match_index = out_midx_r;

endmodule

`default_nettype wire

// ===== rtl/modem_multi_pattern_waiter.sv =====
// Timing: an accepted item enters the front queue at the accepting edge; the back
//   pops it and registers its result in the output register once the output slot
//   is free or draining, and it can be taken from there.
// Throughput: one item per cycle while the output is not stalled; all pattern compares
//   run in parallel and each pattern row RAM serves one prefetch read per cycle.
// Reset (rst_n low, synchronous): pattern store reads empty, positions,
//   wait flag and timeout cleared; items are taken the first cycle after.
`default_nettype none

module modem_multi_pattern_waiter #(
  parameter int NUM_PATTERNS  = mmpw_pkg::NumPatterns,
  parameter int PATTERN_BYTES = mmpw_pkg::PatternBytes
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mmpw_in_if.sink     in_ch,
  mmpw_out_if.source  out_ch
);

  logic           push, q_full, q_not_empty, pop;
  mmpw_pkg::op_t  push_op, pop_op;

  // accept and classify
  mmpw_front #(
    .NUM_PATTERNS  (NUM_PATTERNS),
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .push    (push),
    .push_op (push_op)
  );

  // decoupling queue
  mmpw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_op    (pop_op)
  );

  // matching, timeout and result
  mmpw_back #(
    .NUM_PATTERNS  (NUM_PATTERNS),
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (q_not_empty),
    .op       (pop_op),
    .op_pop   (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

import mmpw_pkg::*;

// one status item as the block reports it
typedef struct packed {
  status_t           status;
  logic [IdxW-1:0]   match_index;
} wait_result_t;

// Tracks the waiter state and the status items still owed by the block
class waiter_scoreboard;
  logic [ValueW-1:0] pat_rows [NumPatterns][PatternBytes];
  logic [PosW-1:0]   match_pos [NumPatterns];
  bit                waiting;
  logic [TickW-1:0]  idle_left;
  logic [TickW-1:0]  reload_ticks;
  wait_result_t      expected_q[$];
  int                mismatches;

  function new();
    foreach (pat_rows[r, c]) pat_rows[r][c] = '0;
    clear_positions();
    waiting      = 1'b0;
    idle_left    = '0;
    reload_ticks = '0;
    mismatches   = 0;
  endfunction

  function void clear_positions();
    foreach (match_pos[i]) match_pos[i] = '0;
  endfunction

  function void end_wait();
    waiting = 1'b0;
    clear_positions();
  endfunction

  // next status item for one accepted input item
  function wait_result_t predict_status(logic [CmdW-1:0] cmd, logic [ValueW-1:0] val,
                                        logic [IdxW-1:0] row, logic [PosW-1:0] col,
                                        logic [SecsW-1:0] secs);
    wait_result_t res;
    logic [31:0]  ticks;
    int           i;
    int           p;
    bit           hit;
    if (waiting) res.status = ST_WAITING;
    else res.status = ST_IDLE;
    res.match_index = '0;
    case (cmd)
      CMD_RX: begin
        if (waiting) begin
          idle_left = reload_ticks;
          // nulls only reload the timeout
          if (val != '0) begin
            hit = 1'b0;
            // index order, first completed pattern wins; a miss is not rechecked
            for (i = 0; i < NumPatterns && !hit; i++) begin
              p = match_pos[i];
              if (p < PatternBytes - 1 && pat_rows[i][p] == val) begin
                p++;
                match_pos[i] = PosW'(p);
                if (pat_rows[i][p] == '0) begin
                  res.status      = ST_MATCHED;
                  res.match_index = IdxW'(i);
                  end_wait();
                  hit = 1'b1;
                end
              end else begin
                match_pos[i] = '0;
              end
            end
          end
        end
      end
      CMD_LOAD: begin
        // last byte of a row is never written
        if (row < NumPatterns && col < PatternBytes - 1) pat_rows[row][col] = val;
      end
      CMD_START: begin
        ticks = 32'(secs) * 32'(TicksPerSec);
        if (ticks == 0) ticks = 32'(DefaultTicks);
        reload_ticks = ticks[TickW-1:0];
        idle_left    = reload_ticks;
        clear_positions();
        waiting      = 1'b1;
        res.status   = ST_WAITING;
      end
      default: begin
        if (waiting) begin
          if (idle_left != '0) idle_left = idle_left - 1'b1;
          if (idle_left == '0) begin
            res.status = ST_TIMEOUT;
            end_wait();
          end
        end
      end
    endcase
    return res;
  endfunction

  function void note_item(logic [CmdW-1:0] cmd, logic [ValueW-1:0] val,
                          logic [IdxW-1:0] row, logic [PosW-1:0] col,
                          logic [SecsW-1:0] secs);
    expected_q.push_back(predict_status(cmd, val, row, col, secs));
  endfunction

  function void check_result(logic [StatusW-1:0] status, logic [IdxW-1:0] midx);
    wait_result_t exp;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected status item: status %0d match_index %0d", status, midx);
    end else begin
      exp = expected_q.pop_front();
      if (status !== exp.status || midx !== exp.match_index) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status item mismatch: status exp %0d got %0d, match_index exp %0d got %0d",
                   exp.status, status, exp.match_index, midx);
      end
    end
  endfunction
endclass

module tb_top;

  localparam int CycleLimit = 300000;
  localparam int ItemTarget = 1300;
  localparam int HoldCycles = 80;

  logic clk;
  logic rst_n;

  mmpw_in_if  in_ch();
  mmpw_out_if out_ch();

  modem_multi_pattern_waiter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  waiter_scoreboard sb = new();

  // what the stimulus believes is loaded, used to build matching byte runs
  logic [ValueW-1:0] loaded_rows [NumPatterns][PatternBytes];
  int useful_items;
  int burst_left;
  int gap_free_left;
  bit gaps_on;
  int hold_ticket = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watch both channels
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_item(in_ch.command, in_ch.value, in_ch.pattern_index, in_ch.char_pos,
                   in_ch.wait_seconds);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.match_index);
  end

  // receiver: changing stall modes plus one long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    int mode;
    int mode_left;
    int period;
    int phase;
    out_ch.ready <= 1'b0;
    hold_seen = 0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    period    = 2;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
        period    = $urandom_range(2, 5);
      end
      mode_left--;
      phase = (phase + 1) % period;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 99) >= 30);
          2: out_ch.ready <= (phase != 0);
          default: out_ch.ready <= ($urandom_range(0, 99) >= 70);
        endcase
      end
    end
  end

  // run limit
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic logic [ValueW-1:0] pick_letter();
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  // offer one item, wait for the handshake, then maybe leave a gap
  task automatic send_item(input cmd_t cmd, input logic [ValueW-1:0] val,
                           input logic [IdxW-1:0] row, input logic [PosW-1:0] col,
                           input logic [SecsW-1:0] secs, input bit counts);
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.value         <= val;
    in_ch.pattern_index <= row;
    in_ch.char_pos      <= col;
    in_ch.wait_seconds  <= secs;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (counts) useful_items++;
    gap = 0;
    if (gap_free_left > 0) begin
      gap_free_left--;
    end else if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
      end
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // don't-care fields of rx, tick and start items carry random bits
  task automatic send_rx(input logic [ValueW-1:0] val);
    send_item(CMD_RX, val, IdxW'($urandom), PosW'($urandom), SecsW'($urandom), 1'b1);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, ValueW'($urandom), IdxW'($urandom), PosW'($urandom),
              SecsW'($urandom), 1'b1);
  endtask

  task automatic send_start(input logic [SecsW-1:0] secs);
    send_item(CMD_START, ValueW'($urandom), IdxW'($urandom), PosW'($urandom), secs, 1'b1);
  endtask

  task automatic send_load(input logic [IdxW-1:0] row, input logic [PosW-1:0] col,
                           input logic [ValueW-1:0] val);
    bit in_range;
    in_range = (row < NumPatterns) && (col < PatternBytes - 1);
    if (in_range) loaded_rows[row][col] = val;
    send_item(CMD_LOAD, val, row, col, SecsW'($urandom), in_range);
  endtask

  task automatic idle_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // write a whole pattern: mostly short, sometimes empty or full length
  task automatic load_pattern(input int row);
    int r;
    int len;
    int j;
    r = $urandom_range(0, 9);
    if (r == 0) len = 0;
    else if (r == 1) len = PatternBytes - 1;
    else len = $urandom_range(1, 6);
    for (j = 0; j < len; j++) begin
      if ($urandom_range(0, 9) < 7) send_load(IdxW'(row), PosW'(j), pick_letter());
      else send_load(IdxW'(row), PosW'(j), 8'($urandom_range(1, 255)));
    end
    if (len < PatternBytes - 1) send_load(IdxW'(row), PosW'(len), 8'h00);
  endtask

  // stream one pattern's bytes, now and then with one byte corrupted
  task automatic feed_pattern(input int row);
    int j;
    int bad_at;
    bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, PatternBytes - 2) : -1;
    for (j = 0; j < PatternBytes - 1 && loaded_rows[row][j] != 8'h00; j++) begin
      if (j == bad_at) send_rx(pick_letter());
      else send_rx(loaded_rows[row][j]);
    end
  endtask

  // a wait with mostly pattern runs and letters from a small alphabet
  task automatic wait_segment();
    int r;
    int steps;
    int k;
    int target;
    r = $urandom_range(0, 9);
    if (r == 0) send_start('0);
    else if (r == 1) send_start(SecsW'($urandom));
    else send_start(SecsW'($urandom_range(1, 5)));
    steps  = $urandom_range(3, 25);
    target = $urandom_range(0, NumPatterns - 1);
    for (k = 0; k < steps; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        feed_pattern(target);
        target = $urandom_range(0, NumPatterns - 1);
      end else if (r < 42) begin
        // repeated leading byte before the run
        send_rx(loaded_rows[target][0]);
        feed_pattern(target);
      end else if (r < 68) begin
        send_rx(pick_letter());
      end else if (r < 75) begin
        send_rx(8'h00);
      end else if (r < 83) begin
        send_rx(ValueW'($urandom));
      end else if (r < 91) begin
        send_tick();
      end else if (r < 97) begin
        send_load(IdxW'($urandom_range(0, NumPatterns - 1)),
                  PosW'($urandom_range(0, PatternBytes - 2)), pick_letter());
      end else begin
        send_start(SecsW'($urandom));
      end
    end
  endtask

  // shortest timeout, optionally kicked once by a null byte, run to expiry
  task automatic timeout_segment();
    int kick;
    int k;
    send_start(SecsW'(1));
    kick = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 90) : 0;
    for (k = 0; k < kick; k++) send_tick();
    if (kick > 0) send_rx(8'h00);
    repeat (int'(TicksPerSec)) send_tick();
    repeat ($urandom_range(1, 2)) send_tick();
  endtask

  // fully random items
  task automatic noise_items();
    cmd_t              cmd;
    logic [IdxW-1:0]   row;
    logic [PosW-1:0]   col;
    repeat ($urandom_range(1, 4)) begin
      cmd = cmd_t'($urandom_range(0, 3));
      row = IdxW'($urandom);
      col = PosW'($urandom);
      if (cmd == CMD_LOAD) send_load(row, col, ValueW'($urandom));
      else send_item(cmd, ValueW'($urandom), row, col, SecsW'($urandom), cmd == CMD_START);
    end
  endtask

  // stimulus
  initial begin
    int r;
    int row;
    bit hold_done;
    bit drain_done;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_RX;
    in_ch.value         <= '0;
    in_ch.pattern_index <= '0;
    in_ch.char_pos      <= '0;
    in_ch.wait_seconds  <= '0;
    foreach (loaded_rows[i, j]) loaded_rows[i][j] = '0;
    useful_items  = 0;
    burst_left    = 0;
    gap_free_left = 0;
    gaps_on       = 1'b1;
    hold_done     = 1'b0;
    drain_done    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle items, rejected loads, short matches, restarts
    send_rx(8'h55);
    send_tick();
    send_load(4'd15, 5'd0, 8'hFF);
    send_load(4'd9, 5'd0, 8'h41);
    send_load(4'd0, 5'd21, 8'h41);
    send_load(4'd0, 5'd31, 8'h7F);
    send_load(4'd0, 5'd0, 8'h41);
    send_load(4'd0, 5'd1, 8'h42);
    send_load(4'd8, 5'd0, 8'hFF);
    send_start(9'd0);
    send_rx(8'h00);
    send_rx(8'h41);
    send_rx(8'h43);
    send_rx(8'h41);
    send_rx(8'h42);
    send_start(9'd327);
    send_load(4'd1, 5'd0, 8'h41);
    send_load(4'd1, 5'd1, 8'h42);
    send_start(9'd1);
    send_rx(8'hFF);
    send_start(9'd511);
    send_tick();
    // pattern 8 emptied while waiting: its old byte no longer matches
    send_load(4'd8, 5'd0, 8'h00);
    send_rx(8'hFF);

    // random: fill every row, then mixed segments
    for (row = 0; row < NumPatterns; row++) load_pattern(row);
    while (useful_items < ItemTarget) begin
      if (!hold_done && useful_items >= 400) begin
        hold_done     = 1'b1;
        gap_free_left = 150;
        hold_ticket  <= hold_ticket + 1;
      end
      if (!drain_done && useful_items >= 800) begin
        drain_done = 1'b1;
        idle_until_drained();
      end
      if ($urandom_range(0, 9) == 0) gaps_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 18) load_pattern($urandom_range(0, NumPatterns - 1));
      else if (r < 75) wait_segment();
      else if (r < 78) timeout_segment();
      else if (r < 95 || gap_free_left > 0) noise_items();
      else idle_until_drained();
    end

    // drain and settle
    idle_until_drained();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
